// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the byte pipe pool.
// Each expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define PPBF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define PPBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define PPBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppbf_pkg.sv =====
// Types and codes for the byte pipe pool: command and status codes, item structs.
// No dependencies; used by the top level.
package ppbf_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC    = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_READ     = 3'd2,
    CMD_CLOSE_RD = 3'd3,
    CMD_CLOSE_WR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_EOD        = 3'd3,
    ST_BROKEN     = 3'd4,
    ST_NONE_FREE  = 3'd5,
    ST_NOT_IN_USE = 3'd6
  } status_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] pipe_id;
    logic [7:0] data_in;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] pipe_out;
    logic [7:0] data_out;
  } rsp_item_t;

endpackage

// ===== rtl/pipe_pool_byte_fifo_unit.sv =====
// Top level of the byte pipe pool: per-pipe counters and flags, command decode, result register.
// Depends on ppbf_pkg, ppbf_ram and assert_macros.svh.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------
//   cmd     | in  | cmd_valid/cmd_stall  | cmd_item: cmd, pipe_id, data_in
//   rsp     | out | rsp_valid/rsp_stall  | rsp_item: status, pipe_out, data_out
//
// One command per cycle while no held result stalls cmd; its result is in the rsp register in the cycle after accept.
// Counters and flags live in flops and are decoded in the accept cycle; the bytes sit in one
// RAM, which a command uses for at most one write or one read. Read data comes straight
// from the RAM output register, which holds while the result waits.
// Reset clears all flags and counters; the byte RAM is not cleared.
// cmd_stall is high exactly when a result is held and rsp_stall is high.
`include "assert_macros.svh"

module pipe_pool_byte_fifo_unit #(
  parameter int PIPE_DEPTH = 32,
  parameter int PIPE_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  ppbf_pkg::cmd_item_t   cmd_item,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output ppbf_pkg::rsp_item_t   rsp_item
);
  import ppbf_pkg::*;

  localparam int IDW    = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1; // pipe index
  localparam int IDX_XW = (IDW > 4) ? IDW : 4;                       // id widened
  localparam int CW     = $clog2(2 * PIPE_DEPTH);                    // counts mod 2*depth
  localparam int SW     = $clog2(PIPE_DEPTH);                        // slot within a pipe
  localparam int MDEPTH = PIPE_COUNT * PIPE_DEPTH;
  localparam int AW     = $clog2(MDEPTH);

  // Per-pipe state
  logic [PIPE_COUNT-1:0] in_use;
  logic [PIPE_COUNT-1:0] reader_open;
  logic [PIPE_COUNT-1:0] writer_open;
  logic [CW-1:0]         rd_cnt [PIPE_COUNT];
  logic [CW-1:0]         wr_cnt [PIPE_COUNT];

  // Result register
  logic       rsp_from_ram;
  logic [2:0] rsp_status;
  logic [3:0] rsp_pipe;

  logic            acc;
  logic [IDX_XW-1:0] id_ext;
  logic [IDW-1:0]  idx;
  logic            id_ok;
  logic [CW-1:0]   rc;
  logic [CW-1:0]   wc;
  logic [CW:0]     fill;
  logic            full;
  logic            empty;
  logic [IDW-1:0]  free_idx;
  logic            free_any;

  logic       do_alloc, do_write, do_read, do_close_rd, do_close_wr;
  logic [2:0] status_next;
  logic [3:0] pipe_next;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    ram_q;
  logic          ram_we;
  logic          ram_re;

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
    return (c == CW'(2 * PIPE_DEPTH - 1)) ? '0 : c + CW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [IDW-1:0] p,
                                               input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = (c >= CW'(PIPE_DEPTH)) ? c - CW'(PIPE_DEPTH) : c;
    return AW'(p) * AW'(PIPE_DEPTH) + AW'(s[SW-1:0]);
  endfunction

  assign cmd_stall = rsp_valid & rsp_stall;
  assign acc       = cmd_valid & ~cmd_stall;

  assign id_ext = IDX_XW'(cmd_item.pipe_id);
  assign idx    = id_ext[IDW-1:0];
  assign id_ok  = (32'(cmd_item.pipe_id) < 32'(PIPE_COUNT)) && in_use[idx];

  assign rc    = rd_cnt[idx];
  assign wc    = wr_cnt[idx];
  // write minus read, modulo twice the depth
  assign fill  = (wc >= rc) ? {1'b0, wc} - {1'b0, rc}
                            : {1'b0, wc} + (CW + 1)'(2 * PIPE_DEPTH) - {1'b0, rc};
  assign full  = fill >= (CW + 1)'(PIPE_DEPTH);
  assign empty = fill == '0;

  // lowest free pipe
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx = IDW'(i);
        free_any = 1'b1;
      end
    end
  end

  // command decode
  always_comb begin
    do_alloc    = 1'b0;
    do_write    = 1'b0;
    do_read     = 1'b0;
    do_close_rd = 1'b0;
    do_close_wr = 1'b0;
    status_next = ST_NOT_IN_USE;
    pipe_next   = '0;
    unique case (cmd_item.cmd)
      CMD_ALLOC: begin
        if (free_any) begin
          do_alloc    = 1'b1;
          status_next = ST_OK;
          pipe_next   = 4'(free_idx);
        end else begin
          status_next = ST_NONE_FREE;
        end
      end
      CMD_WRITE: begin
        if (id_ok) begin
          if (full) begin
            status_next = reader_open[idx] ? ST_FULL : ST_BROKEN;
          end else begin
            do_write    = 1'b1;
            status_next = ST_OK;
          end
        end
      end
      CMD_READ: begin
        if (id_ok) begin
          if (empty) begin
            status_next = writer_open[idx] ? ST_EMPTY : ST_EOD;
          end else begin
            do_read     = 1'b1;
            status_next = ST_OK;
          end
        end
      end
      CMD_CLOSE_RD: begin
        if (id_ok) begin
          do_close_rd = 1'b1;
          status_next = ST_OK;
        end
      end
      CMD_CLOSE_WR: begin
        if (id_ok) begin
          do_close_wr = 1'b1;
          status_next = ST_OK;
        end
      end
      default: begin
        status_next = ST_NOT_IN_USE;
      end
    endcase
  end

  // pipe state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use      <= '0;
      reader_open <= '0;
      writer_open <= '0;
      rd_cnt      <= '{default: '0};
      wr_cnt      <= '{default: '0};
    end else if (acc) begin
      if (do_alloc) begin
        in_use[free_idx]      <= 1'b1;
        reader_open[free_idx] <= 1'b1;
        writer_open[free_idx] <= 1'b1;
        rd_cnt[free_idx]      <= '0;
        wr_cnt[free_idx]      <= '0;
      end
      if (do_write) begin
        wr_cnt[idx] <= cnt_inc(wc);
      end
      if (do_read) begin
        rd_cnt[idx] <= cnt_inc(rc);
      end
      // pipe goes free once both ends are closed
      if (do_close_rd) begin
        reader_open[idx] <= 1'b0;
        if (!writer_open[idx]) begin
          in_use[idx] <= 1'b0;
        end
      end
      if (do_close_wr) begin
        writer_open[idx] <= 1'b0;
        if (!reader_open[idx]) begin
          in_use[idx] <= 1'b0;
        end
      end
    end
  end

  // byte store
  assign wr_addr = slot_addr(idx, wc);
  assign rd_addr = slot_addr(idx, rc);
  assign ram_we  = acc & do_write;
  assign ram_re  = acc & do_read;

  ppbf_ram #(
    .WIDTH (8),
    .DEPTH (MDEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (cmd_item.data_in),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_status   <= status_next;
      rsp_pipe     <= pipe_next;
      rsp_from_ram <= do_read;
    end
  end

  assign rsp_item.status   = rsp_status;
  assign rsp_item.pipe_out = rsp_pipe;
  assign rsp_item.data_out = rsp_from_ram ? ram_q : 8'd0;

  // a pipe is in use exactly while one of its ends is open
  `PPBF_ASSERT_ALWAYS(a_use_vs_open, in_use == (reader_open | writer_open), "in_use out of step with open flags")
  // a successful read shows RAM data in the next result
  `PPBF_ASSERT_NEXT(a_read_data, acc && do_read, rsp_valid && rsp_from_ram, "read result not taken from RAM")
  // RAM output must hold while a result waits
  `PPBF_ASSERT_SAME(a_hold_q, rsp_valid && rsp_stall, !ram_re, "RAM read issued under a held result")
  // failed commands return zero pipe and data
  `PPBF_ASSERT_SAME(a_zero_fail, rsp_valid && rsp_status != ST_OK, rsp_pipe == 4'd0 && !rsp_from_ram, "nonzero payload on failed command")

endmodule

// ===== rtl/ppbf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ppbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
